/* hdl/idq_pkg.sv */
package idq_pkg;

  // Fixed field widths of the stream items
  localparam int WORD_W   = 32;
  localparam int POS_W    = 4;
  localparam int OCC_W    = 5;
  localparam int STATUS_W = 2;
  localparam int ACTION_W = 3;

  // Padded tdata widths (whole bytes)
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  // Default configuration
  localparam int DEPTH_DEF  = 16;
  localparam int DATA_W_DEF = 32;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH_BACK  = 3'd0,
    ACT_PUSH_FRONT = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_READ_AT    = 3'd4,
    ACT_DELETE_AT  = 3'd5
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // Command broadcast to every cell of the row
  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_LOAD_AT    = 2'd1,
    CELL_SHIFT_IN   = 2'd2,
    CELL_CLOSE_FROM = 2'd3
  } cell_cmd_t;

endpackage

/* hdl/idq_cell.sv */
module idq_cell #(
  parameter int DATA_W = idq_pkg::DATA_W_DEF,
  parameter int IDX_W  = 4,
  parameter int INDEX  = 0
) (
  input  logic                   clk,
  input  idq_pkg::cell_cmd_t     cmd,
  input  logic [IDX_W-1:0]       target,
  input  logic [DATA_W-1:0]      load_word,
  input  logic [DATA_W-1:0]      prev_word,
  input  logic [DATA_W-1:0]      next_word,
  output logic [DATA_W-1:0]      word
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic [DATA_W-1:0] word_next;

  // Pick this cell's new content from the broadcast command
  always_comb begin
    word_next = word;
    case (cmd)
      idq_pkg::CELL_LOAD_AT: begin
        if (MY_IDX == target) word_next = load_word;
      end
      idq_pkg::CELL_SHIFT_IN: begin
        word_next = prev_word;
      end
      idq_pkg::CELL_CLOSE_FROM: begin
        if (MY_IDX >= target) word_next = next_word;
      end
      default: begin
        word_next = word;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

/* hdl/indexed_double_ended_queue_unit.sv */
// Bounded double-ended queue of DEPTH words held in a row of cells, entry 0
// at the front. Each transaction on the input stream carries one action in
// tuser (push back, push front, pop front, pop back, read at position,
// delete at position) and gives exactly one result transaction: status in
// tuser, the word popped, read or deleted (zero otherwise) and the occupancy
// after the action. Every action, indexed delete included, is one row update:
// all cells shift together in the same clock, so the block accepts one
// transaction per cycle whenever the result register is free or being taken.

module indexed_double_ended_queue_unit #(
  parameter int DEPTH  = idq_pkg::DEPTH_DEF,
  parameter int DATA_W = idq_pkg::DATA_W_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // tdata: push_word [31:0], position [35:32], zero pad [39:36]
  input  logic [idq_pkg::IN_TDATA_W-1:0]  s_tdata,
  // tuser: action [2:0]
  input  logic [idq_pkg::ACTION_W-1:0]    s_tuser,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // tdata: out_word [31:0], occupancy [36:32], zero pad [39:37]
  output logic [idq_pkg::OUT_TDATA_W-1:0] m_tdata,
  // tuser: status [1:0]
  output logic [idq_pkg::STATUS_W-1:0]    m_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready
);

  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = (CNT_W > idq_pkg::POS_W) ? CNT_W : idq_pkg::POS_W;
  localparam int WEXT_W = (DATA_W > idq_pkg::WORD_W) ? DATA_W : idq_pkg::WORD_W;
  localparam int OEXT_W = (CNT_W > idq_pkg::OCC_W) ? CNT_W : idq_pkg::OCC_W;
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);

  // Control registers
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  // Result register
  idq_pkg::status_t            res_status;
  logic [idq_pkg::WORD_W-1:0]  res_word;
  logic [idq_pkg::OCC_W-1:0]   res_occ;

  // Decode
  logic                        accept;
  idq_pkg::action_t            action;
  logic [idq_pkg::WORD_W-1:0]  push_word;
  logic [idq_pkg::POS_W-1:0]   position;
  logic [WEXT_W-1:0]           push_ext;
  logic [DATA_W-1:0]           load_word;
  logic                        full;
  logic                        empty;
  logic                        in_range;
  logic [CMP_W-1:0]            pos_cmp;
  logic [CMP_W-1:0]            cnt_cmp;
  logic [IDX_W-1:0]            pos_idx;
  logic [CNT_W-1:0]            cnt_m1;
  logic [IDX_W-1:0]            rd_idx;
  logic [DATA_W-1:0]           rd_word;
  logic [WEXT_W-1:0]           rd_ext;
  logic [OEXT_W-1:0]           occ_ext;
  idq_pkg::cell_cmd_t          cmd;
  logic [IDX_W-1:0]            target;
  idq_pkg::status_t            status_next;
  logic                        take_word;

  logic [DATA_W-1:0] cell_word [DEPTH];

  assign accept    = s_tvalid && s_tready;
  assign s_tready  = !m_tvalid || m_tready;

  assign action    = idq_pkg::action_t'(s_tuser);
  assign push_word = s_tdata[idq_pkg::WORD_W-1:0];
  assign position  = s_tdata[idq_pkg::WORD_W +: idq_pkg::POS_W];
  assign push_ext  = WEXT_W'(push_word);
  assign load_word = push_ext[DATA_W-1:0];

  assign full     = (count == DEPTH_CNT);
  assign empty    = (count == '0);
  assign pos_cmp  = CMP_W'(position);
  assign cnt_cmp  = CMP_W'(count);
  assign in_range = (pos_cmp < cnt_cmp);
  assign pos_idx  = pos_cmp[IDX_W-1:0];
  assign cnt_m1   = count - ONE_CNT;

  // Decode the action into a cell command, a read index and a new count
  always_comb begin
    cmd         = idq_pkg::CELL_HOLD;
    target      = '0;
    rd_idx      = '0;
    take_word   = 1'b0;
    status_next = idq_pkg::ST_OK;
    count_next  = count;
    case (action)
      idq_pkg::ACT_PUSH_BACK: begin
        if (full) begin
          status_next = idq_pkg::ST_FULL;
        end else begin
          cmd        = idq_pkg::CELL_LOAD_AT;
          target     = count[IDX_W-1:0];
          count_next = count + ONE_CNT;
        end
      end
      idq_pkg::ACT_PUSH_FRONT: begin
        if (full) begin
          status_next = idq_pkg::ST_FULL;
        end else begin
          cmd        = idq_pkg::CELL_SHIFT_IN;
          count_next = count + ONE_CNT;
        end
      end
      idq_pkg::ACT_POP_FRONT: begin
        if (empty) begin
          status_next = idq_pkg::ST_EMPTY;
        end else begin
          cmd        = idq_pkg::CELL_CLOSE_FROM;
          take_word  = 1'b1;
          count_next = cnt_m1;
        end
      end
      idq_pkg::ACT_POP_BACK: begin
        if (empty) begin
          status_next = idq_pkg::ST_EMPTY;
        end else begin
          rd_idx     = cnt_m1[IDX_W-1:0];
          take_word  = 1'b1;
          count_next = cnt_m1;
        end
      end
      idq_pkg::ACT_READ_AT: begin
        if (!in_range) begin
          status_next = idq_pkg::ST_RANGE;
        end else begin
          rd_idx    = pos_idx;
          take_word = 1'b1;
        end
      end
      idq_pkg::ACT_DELETE_AT: begin
        if (!in_range) begin
          status_next = idq_pkg::ST_RANGE;
        end else begin
          cmd        = idq_pkg::CELL_CLOSE_FROM;
          target     = pos_idx;
          rd_idx     = pos_idx;
          take_word  = 1'b1;
          count_next = cnt_m1;
        end
      end
      default: begin
        status_next = idq_pkg::ST_OK;
      end
    endcase
    if (!accept) begin
      cmd = idq_pkg::CELL_HOLD;
    end
  end

  // Row of cells; each neighbour feeds the next in both directions
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] prev_w;
    logic [DATA_W-1:0] next_w;
    if (i == 0) begin : g_first
      assign prev_w = load_word;
    end else begin : g_mid
      assign prev_w = cell_word[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_w = cell_word[i];
    end else begin : g_inner
      assign next_w = cell_word[i+1];
    end
    idq_cell #(
      .DATA_W (DATA_W),
      .IDX_W  (IDX_W),
      .INDEX  (i)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .target    (target),
      .load_word (load_word),
      .prev_word (prev_w),
      .next_word (next_w),
      .word      (cell_word[i])
    );
  end

  // Select the word leaving the queue
  assign rd_word = cell_word[rd_idx];
  assign rd_ext  = WEXT_W'(rd_word);
  assign occ_ext = OEXT_W'(count_next);

  // Hold occupancy and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Capture the result transaction
  always_ff @(posedge clk) begin
    if (accept) begin
      res_status <= status_next;
      res_word   <= take_word ? rd_ext[idq_pkg::WORD_W-1:0] : '0;
      res_occ    <= occ_ext[idq_pkg::OCC_W-1:0];
    end
  end

  assign m_tuser = res_status;
  assign m_tdata = {{(idq_pkg::OUT_TDATA_W - idq_pkg::WORD_W - idq_pkg::OCC_W){1'b0}},
                    res_occ, res_word};

endmodule

/* test/indexed_double_ended_queue_unit_tb.sv */
module indexed_double_ended_queue_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WORD_W      = idq_pkg::WORD_W;
  localparam int POS_W       = idq_pkg::POS_W;
  localparam int OCC_W       = idq_pkg::OCC_W;
  localparam int STATUS_W    = idq_pkg::STATUS_W;
  localparam int ACTION_W    = idq_pkg::ACTION_W;
  localparam int IN_TDATA_W  = idq_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W = idq_pkg::OUT_TDATA_W;

  // Action codes the block ignores
  localparam logic [ACTION_W-1:0] ACT_SPARE_6 = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_SPARE_7 = 3'd7;

  localparam int CAPACITY    = idq_pkg::DEPTH_DEF;
  localparam int RANDOM_OPS  = 1500;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_WAIT  = 8;

  typedef struct packed {
    idq_pkg::status_t  status;
    logic [WORD_W-1:0] word;
    logic [OCC_W-1:0]  occ;
  } deque_result_t;

  typedef struct {
    logic [ACTION_W-1:0] act;
    logic [WORD_W-1:0]   word;
    logic [POS_W-1:0]    pos;
    int                  reps;
    bit                  typed;
    deque_result_t       outcome;
  } op_row_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic [ACTION_W-1:0]    s_tuser;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [STATUS_W-1:0]    m_tuser;
  logic                   m_tvalid;
  logic                   m_tready;

  // Shadow copy of the deque contents
  logic [WORD_W-1:0] shadow_cells [CAPACITY];
  int                shadow_count = 0;

  deque_result_t pending_results [$];
  logic          took_input = 1'b0;
  bit            row_typed = 1'b0;
  deque_result_t row_outcome = '0;
  bit            calm = 1'b0;
  int            mismatches = 0;
  int            cycle_count = 0;
  int            results_seen = 0;
  int            action_seen [8];
  int            status_seen [4];

  // Directed operations; outcomes are written out where they are obvious
  op_row_t directed_ops [15] = '{
    '{idq_pkg::ACT_POP_FRONT,  32'h0000_0000, 4'h0, 1,  1'b1,
      '{idq_pkg::ST_EMPTY, 32'h0, 5'd0}},
    '{idq_pkg::ACT_POP_BACK,   32'hffff_ffff, 4'hf, 1,  1'b1,
      '{idq_pkg::ST_EMPTY, 32'h0, 5'd0}},
    '{idq_pkg::ACT_READ_AT,    32'h0000_0000, 4'h0, 1,  1'b1,
      '{idq_pkg::ST_RANGE, 32'h0, 5'd0}},
    '{ACT_SPARE_6,             32'hffff_ffff, 4'hf, 1,  1'b1,
      '{idq_pkg::ST_OK,    32'h0, 5'd0}},
    '{idq_pkg::ACT_PUSH_BACK,  32'hffff_ffff, 4'h0, 1,  1'b1,
      '{idq_pkg::ST_OK,    32'h0, 5'd1}},
    '{idq_pkg::ACT_PUSH_FRONT, 32'h0000_0000, 4'hf, 1,  1'b1,
      '{idq_pkg::ST_OK,    32'h0, 5'd2}},
    '{idq_pkg::ACT_READ_AT,    32'h0000_0000, 4'h1, 1,  1'b1,
      '{idq_pkg::ST_OK, 32'hffff_ffff, 5'd2}},
    '{idq_pkg::ACT_PUSH_BACK,  32'h0000_0000, 4'h0, 14, 1'b0, '0},
    '{idq_pkg::ACT_PUSH_BACK,  32'ha5a5_a5a5, 4'h0, 1,  1'b1,
      '{idq_pkg::ST_FULL,  32'h0, 5'd16}},
    '{idq_pkg::ACT_PUSH_FRONT, 32'h5a5a_5a5a, 4'h0, 1,  1'b1,
      '{idq_pkg::ST_FULL,  32'h0, 5'd16}},
    '{idq_pkg::ACT_DELETE_AT,  32'h0000_0000, 4'hf, 1,  1'b0, '0},
    '{idq_pkg::ACT_DELETE_AT,  32'h0000_0000, 4'h0, 1,  1'b1,
      '{idq_pkg::ST_OK,    32'h0, 5'd14}},
    '{idq_pkg::ACT_DELETE_AT,  32'h0000_0000, 4'he, 1,  1'b1,
      '{idq_pkg::ST_RANGE, 32'h0, 5'd14}},
    '{idq_pkg::ACT_POP_FRONT,  32'h0000_0000, 4'h0, 1,  1'b1,
      '{idq_pkg::ST_OK, 32'hffff_ffff, 5'd13}},
    '{idq_pkg::ACT_POP_BACK,   32'h0000_0000, 4'h0, 1,  1'b0, '0}
  };

  indexed_double_ended_queue_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Carry out one action on the shadow deque and return its outcome
  function automatic deque_result_t apply_action(logic [ACTION_W-1:0] act,
                                                 logic [WORD_W-1:0] word,
                                                 logic [POS_W-1:0] pos);
    deque_result_t r;
    int i;
    r.status = idq_pkg::ST_OK;
    r.word   = '0;
    case (act)
      idq_pkg::ACT_PUSH_BACK: begin
        if (shadow_count >= CAPACITY) begin
          r.status = idq_pkg::ST_FULL;
        end else begin
          shadow_cells[shadow_count] = word;
          shadow_count++;
        end
      end
      idq_pkg::ACT_PUSH_FRONT: begin
        if (shadow_count >= CAPACITY) begin
          r.status = idq_pkg::ST_FULL;
        end else begin
          for (i = shadow_count; i > 0; i--) shadow_cells[i] = shadow_cells[i-1];
          shadow_cells[0] = word;
          shadow_count++;
        end
      end
      idq_pkg::ACT_POP_FRONT: begin
        if (shadow_count == 0) begin
          r.status = idq_pkg::ST_EMPTY;
        end else begin
          r.word = shadow_cells[0];
          for (i = 0; i + 1 < shadow_count; i++) shadow_cells[i] = shadow_cells[i+1];
          shadow_count--;
        end
      end
      idq_pkg::ACT_POP_BACK: begin
        if (shadow_count == 0) begin
          r.status = idq_pkg::ST_EMPTY;
        end else begin
          shadow_count--;
          r.word = shadow_cells[shadow_count];
        end
      end
      idq_pkg::ACT_READ_AT: begin
        if (int'(pos) >= shadow_count) r.status = idq_pkg::ST_RANGE;
        else r.word = shadow_cells[pos];
      end
      idq_pkg::ACT_DELETE_AT: begin
        if (int'(pos) >= shadow_count) begin
          r.status = idq_pkg::ST_RANGE;
        end else begin
          r.word = shadow_cells[pos];
          for (i = int'(pos); i + 1 < shadow_count; i++) shadow_cells[i] = shadow_cells[i+1];
          shadow_count--;
        end
      end
      default: ;
    endcase
    r.occ = OCC_W'(shadow_count);
    return r;
  endfunction

  task automatic check_field(string field, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %h, got %h", field, want, got);
      mismatches++;
    end
  endtask

  // Predict on each input transaction, compare on each output transaction
  always @(posedge clk) begin
    deque_result_t predicted;
    deque_result_t oldest;
    took_input <= !rst && s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) begin
      predicted = apply_action(s_tuser, s_tdata[WORD_W-1:0], s_tdata[WORD_W +: POS_W]);
      pending_results.push_back(row_typed ? row_outcome : predicted);
      action_seen[s_tuser]++;
    end
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      status_seen[m_tuser]++;
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing outstanding: tdata %h tuser %h",
               m_tdata, m_tuser);
        mismatches++;
      end else begin
        oldest = pending_results.pop_front();
        check_field("status", WORD_W'(oldest.status), WORD_W'(m_tuser));
        check_field("out_word", oldest.word, m_tdata[WORD_W-1:0]);
        check_field("occupancy", WORD_W'(oldest.occ), WORD_W'(m_tdata[WORD_W +: OCC_W]));
        check_field("tdata pad", '0, WORD_W'(m_tdata[OUT_TDATA_W-1:WORD_W+OCC_W]));
      end
    end
  end

  // Guard against a hung handshake
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timed out after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("indexed_double_ended_queue_unit_tb NOT OK");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Bias the mix: 0 fills, 1 drains, 2 balanced
  function automatic logic [ACTION_W-1:0] pick_action(int mode);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return ($urandom_range(0, 1) != 0) ? ACT_SPARE_7 : ACT_SPARE_6;
    r = $urandom_range(0, 99);
    case (mode)
      0: begin
        if (r < 40) return idq_pkg::ACT_PUSH_BACK;
        if (r < 70) return idq_pkg::ACT_PUSH_FRONT;
        if (r < 78) return idq_pkg::ACT_POP_FRONT;
        if (r < 86) return idq_pkg::ACT_POP_BACK;
        if (r < 93) return idq_pkg::ACT_READ_AT;
        return idq_pkg::ACT_DELETE_AT;
      end
      1: begin
        if (r < 15) return idq_pkg::ACT_PUSH_BACK;
        if (r < 25) return idq_pkg::ACT_PUSH_FRONT;
        if (r < 45) return idq_pkg::ACT_POP_FRONT;
        if (r < 65) return idq_pkg::ACT_POP_BACK;
        if (r < 80) return idq_pkg::ACT_READ_AT;
        return idq_pkg::ACT_DELETE_AT;
      end
      default: begin
        if (r < 20) return idq_pkg::ACT_PUSH_BACK;
        if (r < 40) return idq_pkg::ACT_PUSH_FRONT;
        if (r < 52) return idq_pkg::ACT_POP_FRONT;
        if (r < 64) return idq_pkg::ACT_POP_BACK;
        if (r < 82) return idq_pkg::ACT_READ_AT;
        return idq_pkg::ACT_DELETE_AT;
      end
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return WORD_W'(1) << $urandom_range(0, WORD_W-1);
      default: return $urandom;
    endcase
  endfunction

  // Mostly positions that hit a held entry, the rest anywhere
  function automatic logic [POS_W-1:0] pick_pos();
    if (shadow_count > 0 && $urandom_range(0, 4) != 0)
      return POS_W'($urandom_range(0, shadow_count - 1));
    return POS_W'($urandom_range(0, CAPACITY - 1));
  endfunction

  // Present one transaction after an optional gap and hold it until taken
  task automatic send_op(logic [ACTION_W-1:0] act, logic [WORD_W-1:0] word,
                         logic [POS_W-1:0] pos, bit typed, deque_result_t outcome);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tuser     <= act;
    s_tdata     <= {{(IN_TDATA_W-WORD_W-POS_W){1'b0}}, pos, word};
    s_tvalid    <= 1'b1;
    row_typed   <= typed;
    row_outcome <= outcome;
    do @(negedge clk); while (!took_input);
  endtask

  // Result side back-pressure: ready runs broken by stalls
  initial begin
    int run;
    int stall;
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 8);
      m_tready <= 1'b1;
      repeat (run) @(negedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
    end
  end

  initial begin
    int k;
    int n;
    int mode;
    rst      = 1'b1;
    s_tdata  = '0;
    s_tuser  = '0;
    s_tvalid = 1'b0;
    foreach (action_seen[i]) action_seen[i] = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Walk the directed operations
    foreach (directed_ops[k]) begin
      for (n = 0; n < directed_ops[k].reps; n++) begin
        send_op(directed_ops[k].act,
                (directed_ops[k].reps > 1) ? WORD_W'($urandom) : directed_ops[k].word,
                directed_ops[k].pos, directed_ops[k].typed, directed_ops[k].outcome);
      end
    end

    // Random bursts, each leaning towards fill, drain or balance
    mode = 2;
    for (k = 0; k < RANDOM_OPS; k++) begin
      if (k % 60 == 0) begin
        mode = $urandom_range(0, 2);
        calm = ($urandom_range(0, 3) == 0);
      end
      send_op(pick_action(mode), pick_word(), pick_pos(), 1'b0, '0);
    end
    s_tvalid <= 1'b0;

    // Drain outstanding results, then let the block settle
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);

    $display(
      "pushes %0d back, %0d front; pops %0d front, %0d back; reads %0d; deletes %0d; spare %0d",
      action_seen[idq_pkg::ACT_PUSH_BACK], action_seen[idq_pkg::ACT_PUSH_FRONT],
      action_seen[idq_pkg::ACT_POP_FRONT], action_seen[idq_pkg::ACT_POP_BACK],
      action_seen[idq_pkg::ACT_READ_AT], action_seen[idq_pkg::ACT_DELETE_AT],
      action_seen[ACT_SPARE_6] + action_seen[ACT_SPARE_7]);
    $display("results %0d: ok %0d, empty %0d, out of range %0d, full %0d; %0d mismatches",
             results_seen, status_seen[idq_pkg::ST_OK], status_seen[idq_pkg::ST_EMPTY],
             status_seen[idq_pkg::ST_RANGE], status_seen[idq_pkg::ST_FULL], mismatches);
    if (mismatches == 0) begin
      $display("indexed_double_ended_queue_unit_tb OK");
    end else begin
      $display("indexed_double_ended_queue_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/idq_pkg.sv
hdl/idq_cell.sv
hdl/indexed_double_ended_queue_unit.sv
test/indexed_double_ended_queue_unit_tb.sv
